@@ design/assert_macros.svh @@
// Assertion macros shared by the near-duplicate block dedup design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define NDBD_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define NDBD_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ndbd_pkg.sv @@
// Types, codes and helper functions shared by the near-duplicate block dedup design.
package ndbd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int WIDTH_W     = 5;
    localparam int THRESH_W    = 8;
    localparam int PTR_W       = 16;
    localparam int GROUP_LANES = 8;
    localparam int GROUP_W     = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HI_BYTE_FIRST   = 2'd2;

    localparam logic [WIDTH_W-1:0]  BLOCK_WIDTH_RESET     = 5'd8;
    localparam logic [THRESH_W-1:0] MATCH_THRESHOLD_RESET = 8'd1;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       is_new;
        logic       store_full;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SCALE,
        ST_BEAT0,
        ST_BEAT1
    } state_t;

    typedef struct packed {
        logic take;
        logic issue;
        logic decide;
        logic scale;
        logic second;
    } cmd_t;

    typedef struct packed {
        logic block_done;
        logic scan_end;
        logic pipe_empty;
    } status_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

@@ design/ndbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ndbd_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/ndbd_ctrl.sv @@
// Controller state machine that sequences byte intake, store search, decision, pointer scaling and result beats.
`include "assert_macros.svh"

module ndbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  ndbd_pkg::status_t st,
    output ndbd_pkg::cmd_t    cmd
);

    import ndbd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && st.block_done)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (st.scan_end && st.pipe_empty)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_BEAT0;
            end
            ST_BEAT0:
            begin
                if (!result_stall)
                begin
                    state_next = ST_BEAT1;
                end
            end
            ST_BEAT1:
            begin
                if (!result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall   = 1'b1;
        result_valid = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.take   = item_valid;
            end
            ST_SEARCH:
            begin
                cmd.issue = !st.scan_end;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            ST_SCALE:
            begin
                cmd.scale = 1'b1;
            end
            ST_BEAT0:
            begin
                result_valid = 1'b1;
            end
            ST_BEAT1:
            begin
                result_valid = 1'b1;
                cmd.second   = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // Intake and result delivery never overlap.
    `NDBD_CHECK(a_one_side_open, !(result_valid && !item_stall), "input open while a result is shown")
    // A delivered first beat is always followed by the second beat.
    `NDBD_IMPLY(a_beat_order, state_reg == ST_BEAT0 && !result_stall, state_reg == ST_BEAT1, "second pointer beat skipped")

endmodule

@@ design/ndbd_dp.sv @@
// Datapath: configuration registers, block buffer, store RAM, distance pipeline and result registers.
`include "assert_macros.svh"

module ndbd_dp #(
    parameter int BLOCK_MAX    = 16,
    parameter int STORE_BLOCKS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [ndbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ndbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  ndbd_pkg::in_item_t                  item,
    output ndbd_pkg::out_item_t                 result,
    input  ndbd_pkg::cmd_t                      cmd,
    output ndbd_pkg::status_t                   st
);

    import ndbd_pkg::*;

    localparam int PW    = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
    localparam int AW    = $clog2(STORE_BLOCKS);
    localparam int CW    = $clog2(STORE_BLOCKS + 1);
    localparam int ROW_W = 8 * BLOCK_MAX;
    localparam int NG    = (BLOCK_MAX + GROUP_LANES - 1) / GROUP_LANES;
    localparam int DW    = $clog2(8 * BLOCK_MAX + 1);

    logic [WIDTH_W-1:0]  width_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic                hi_first_reg;

    logic [PW-1:0] pos_reg;
    logic [CW-1:0] stored_reg;
    logic [CW-1:0] scan_reg;
    logic [7:0]    buf_reg [BLOCK_MAX];

    logic [WIDTH_W-1:0] eff_w;
    logic               data_take;

    logic             v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]    idx1_reg, idx2_reg, idx3_reg;
    logic [3:0]       lane_reg [BLOCK_MAX];
    logic [GROUP_W-1:0] grp_reg [NG];
    logic [DW-1:0]    ham_dist;

    logic             found_reg;
    logic [AW-1:0]    hit_reg;
    logic [AW-1:0]    sel_idx_reg;
    logic             fresh_reg;
    logic             full_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [AW+WIDTH_W-1:0] prod;

    logic             ram_we;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic             has_room;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WIDTH_W'(1);
        end
        else if (int'(width_reg) > BLOCK_MAX)
        begin
            eff_w = WIDTH_W'(BLOCK_MAX);
        end
        else
        begin
            eff_w = width_reg;
        end
    end

    assign data_take     = cmd.take && (item.op == OP_DATA);
    assign st.block_done = (item.op == OP_DATA) && (int'(pos_reg) + 1 >= int'(eff_w));
    assign st.scan_end   = (scan_reg == stored_reg);
    assign st.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign has_room      = int'(stored_reg) < STORE_BLOCKS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= BLOCK_WIDTH_RESET;
            thresh_reg   <= MATCH_THRESHOLD_RESET;
            hi_first_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_BLOCK_WIDTH:     width_reg    <= cfg_data[WIDTH_W-1:0];
                REG_MATCH_THRESHOLD: thresh_reg   <= cfg_data[THRESH_W-1:0];
                REG_HI_BYTE_FIRST:   hi_first_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            stored_reg <= '0;
            scan_reg   <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (item.op == OP_CLEAR)
                begin
                    pos_reg    <= '0;
                    stored_reg <= '0;
                end
                else if (st.block_done)
                begin
                    pos_reg   <= '0;
                    scan_reg  <= '0;
                    found_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + PW'(1);
                end
            end
            if (cmd.issue)
            begin
                scan_reg <= scan_reg + CW'(1);
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg && (int'(ham_dist) < int'(thresh_reg)))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.decide && !found_reg && has_room)
            begin
                stored_reg <= stored_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_take)
        begin
            buf_reg[pos_reg] <= item.data_byte;
        end
    end

    always_comb
    begin
        for (int k = 0; k < BLOCK_MAX; k++)
        begin
            ram_wdata[8*k +: 8] = buf_reg[k];
        end
    end

    assign ram_we = cmd.decide && !found_reg && has_room;

    ndbd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (STORE_BLOCKS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (stored_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (scan_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    function automatic logic [GROUP_W-1:0] grp_sum(input int g);
        logic [GROUP_W-1:0] s;
        s = '0;
        for (int i = 0; i < GROUP_LANES; i++)
        begin
            if (g * GROUP_LANES + i < BLOCK_MAX)
            begin
                s = s + GROUP_W'(lane_reg[g * GROUP_LANES + i]);
            end
        end
        return s;
    endfunction

    // Distance pipeline: per-byte bit counts, group sums of eight lanes, then the final sum.
    always_ff @(posedge clk)
    begin
        idx1_reg <= scan_reg[AW-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        for (int k = 0; k < BLOCK_MAX; k++)
        begin
            if (k < int'(eff_w))
            begin
                lane_reg[k] <= popcount8(ram_rdata[8*k +: 8] ^ buf_reg[k]);
            end
            else
            begin
                lane_reg[k] <= 4'd0;
            end
        end
        for (int g = 0; g < NG; g++)
        begin
            grp_reg[g] <= grp_sum(g);
        end
        if (v3_reg && (int'(ham_dist) < int'(thresh_reg)))
        begin
            hit_reg <= idx3_reg;
        end
    end

    always_comb
    begin
        ham_dist = '0;
        for (int g = 0; g < NG; g++)
        begin
            ham_dist = ham_dist + DW'(grp_reg[g]);
        end
    end

    // Decision and pointer scaling.
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            if (found_reg)
            begin
                sel_idx_reg <= hit_reg;
                fresh_reg   <= 1'b0;
                full_reg    <= 1'b0;
            end
            else if (has_room)
            begin
                sel_idx_reg <= stored_reg[AW-1:0];
                fresh_reg   <= 1'b1;
                full_reg    <= 1'b0;
            end
            else
            begin
                sel_idx_reg <= '0;
                fresh_reg   <= 1'b0;
                full_reg    <= 1'b1;
            end
        end
        if (cmd.scale)
        begin
            ptr_reg <= PTR_W'(prod);
        end
    end

    assign prod = sel_idx_reg * eff_w;

    always_comb
    begin
        result.table_byte = (hi_first_reg ^ cmd.second) ? ptr_reg[15:8] : ptr_reg[7:0];
        result.is_new     = fresh_reg;
        result.store_full = full_reg;
        result.last       = cmd.second;
    end

    // The fill count never runs past the store depth.
    `NDBD_CHECK(a_stored_bound, int'(stored_reg) <= STORE_BLOCKS, "store fill count overflow")
    // An append always bumps the fill count by one.
    `NDBD_IMPLY(a_append_counts, cmd.decide && !found_reg && has_room, stored_reg == $past(stored_reg) + 1'b1, "append did not advance fill count")

endmodule

@@ design/near_duplicate_block_dedup_core.sv @@
// Top level of the near-duplicate block dedup core: controller plus datapath.
//
//   Channel  | Direction | Handshake                | Payload
//   ---------+-----------+--------------------------+---------------------------------
//   item     | in        | item_valid / item_stall  | op, data_byte
//   result   | out       | result_valid / result_stall | table_byte, is_new, store_full, last
//   cfg      | in        | cfg_write_en             | cfg_index, cfg_data
//
// A data byte that does not complete a block, and a clear beat, are each taken at once and
// leave the input open. A completing byte keeps the input stalled while the core reads one
// store row per cycle, drains the distance pipeline, decides, scales the pointer and shows
// each of the two result beats; with an empty store no row is read. The next beat is taken
// once the second result beat has gone out, if nothing stalls.
// Reset is asynchronous and active low; it restores the register defaults and empties the
// store by clearing its fill count, so no clearing pass runs.
// A stall on the result side holds the current pointer beat and keeps the input stalled.
module near_duplicate_block_dedup_core #(
    parameter int BLOCK_MAX    = 16,
    parameter int STORE_BLOCKS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [ndbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ndbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  ndbd_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ndbd_pkg::out_item_t                 result
);

    import ndbd_pkg::*;

    // Commands flow from the controller to the datapath; status flows back.
    cmd_t    cmd;
    status_t st;

    // The controller decides when a beat is taken, when the store is scanned and when
    // the two pointer beats are shown.
    ndbd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .st           (st),
        .cmd          (cmd)
    );

    // The datapath holds the configuration, the block buffer, the store and the
    // Hamming distance pipeline, and forms the result payload.
    ndbd_dp #(
        .BLOCK_MAX    (BLOCK_MAX),
        .STORE_BLOCKS (STORE_BLOCKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result       (result),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

@@ dv/dedup_checker.sv @@
// Checker for the near-duplicate block dedup core: predicts and compares pointer beats.
module dedup_checker #(
    parameter int BLOCK_MAX    = 16,
    parameter int STORE_BLOCKS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [ndbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ndbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  ndbd_pkg::in_item_t               item,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  ndbd_pkg::out_item_t              result,
    output int                               mismatches,
    output int                               beats_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import ndbd_pkg::*;

    // Shadow copy of the block store, the block being gathered and the registers.
    logic [7:0]      slots [STORE_BLOCKS][BLOCK_MAX];
    logic [7:0]      gather [BLOCK_MAX];
    int unsigned     fill_pos;
    int unsigned     entries;
    logic [4:0]      width_reg;
    logic [7:0]      thresh_reg;
    logic            hi_first_reg;
    int              fail_total;
    out_item_t       pointer_beats_due [$];

    // Takes one accepted input beat and queues the pointer beats it should cause.
    task automatic absorb_beat(input in_item_t beat);
        int unsigned w;
        int unsigned bit_diffs;
        int unsigned hit;
        int unsigned ptr;
        logic [7:0]  diff;
        bit          found;
        bit          fresh;
        bit          full;
        out_item_t   lead;
        out_item_t   tail;
        if (beat.op == OP_CLEAR)
        begin
            entries  = 0;
            fill_pos = 0;
        end
        else
        begin
            w = (width_reg == 5'd0) ? 1 : (width_reg > BLOCK_MAX) ? BLOCK_MAX : width_reg;
            gather[fill_pos] = beat.data_byte;
            if (fill_pos + 1 < w)
            begin
                fill_pos++;
            end
            else
            begin
                fill_pos = 0;
                found    = 1'b0;
                fresh    = 1'b0;
                full     = 1'b0;
                hit      = 0;
                // The last entry under the threshold wins.
                for (int unsigned j = 0; j < entries; j++)
                begin
                    bit_diffs = 0;
                    for (int unsigned k = 0; k < w; k++)
                    begin
                        diff = slots[j][k] ^ gather[k];
                        for (int b = 0; b < 8; b++)
                        begin
                            bit_diffs += diff[b];
                        end
                    end
                    if (bit_diffs < thresh_reg)
                    begin
                        hit   = j;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    ptr = hit * w;
                end
                else if (entries < STORE_BLOCKS)
                begin
                    for (int unsigned k = 0; k < w; k++)
                    begin
                        slots[entries][k] = gather[k];
                    end
                    ptr   = entries * w;
                    entries++;
                    fresh = 1'b1;
                end
                else
                begin
                    ptr  = 0;
                    full = 1'b1;
                end
                lead.table_byte = hi_first_reg ? ptr[15:8] : ptr[7:0];
                lead.is_new     = fresh;
                lead.store_full = full;
                lead.last       = 1'b0;
                tail.table_byte = hi_first_reg ? ptr[7:0] : ptr[15:8];
                tail.is_new     = fresh;
                tail.store_full = full;
                tail.last       = 1'b1;
                pointer_beats_due = {pointer_beats_due, lead, tail};
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fill_pos     = 0;
            entries      = 0;
            width_reg    = BLOCK_WIDTH_RESET;
            thresh_reg   = MATCH_THRESHOLD_RESET;
            hi_first_reg = 1'b0;
            fail_total   = 0;
            pointer_beats_due.delete();
            mismatches <= 0;
            beats_owed <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_BLOCK_WIDTH:     width_reg    = cfg_data[4:0];
                    REG_MATCH_THRESHOLD: thresh_reg   = cfg_data[7:0];
                    REG_HI_BYTE_FIRST:   hi_first_reg = cfg_data[0];
                    default:             ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                absorb_beat(item);
            end
            if (result_valid && !result_stall)
            begin
                if (pointer_beats_due.size() == 0)
                begin
                    $display("%0t: unexpected pointer beat, expected none, got %h",
                             $time, result);
                    fail_total++;
                end
                else
                begin
                    want = pointer_beats_due.pop_front();
                    if (result.table_byte !== want.table_byte)
                    begin
                        $display("%0t: table_byte expected %h, got %h",
                                 $time, want.table_byte, result.table_byte);
                        fail_total++;
                    end
                    if (result.is_new !== want.is_new)
                    begin
                        $display("%0t: is_new expected %b, got %b",
                                 $time, want.is_new, result.is_new);
                        fail_total++;
                    end
                    if (result.store_full !== want.store_full)
                    begin
                        $display("%0t: store_full expected %b, got %b",
                                 $time, want.store_full, result.store_full);
                        fail_total++;
                    end
                    if (result.last !== want.last)
                    begin
                        $display("%0t: last expected %b, got %b",
                                 $time, want.last, result.last);
                        fail_total++;
                    end
                end
            end
            beats_owed <= pointer_beats_due.size();
            mismatches <= fail_total;
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the dedup core testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ndbd_pkg::*;

    localparam int BLOCK_MAX     = 16;
    localparam int STORE_BLOCKS  = 256;
    // The limit covers the worst case per beat (full store search, two stalled
    // pointer beats, a sender gap) over roughly 850 beats, taken four times over.
    localparam int CYCLE_LIMIT   = 1000000;
    // Lets a trailing beat that completes no block finish inside the core.
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 64;
    localparam int HOLD_CYCLES   = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    int        mismatches;
    int        beats_owed;

    // Stimulus bookkeeping. cur_width is the effective block width in force;
    // run_floor is the smallest width in force since the store was last
    // emptied. Raising the width above run_floor would make the core compare
    // store bytes that were never written, so such a raise is followed by a
    // clear beat.
    int unsigned beats_sent = 0;
    int unsigned cur_width = 8;
    int unsigned run_floor = 8;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned cycle_count = 0;

    // Recently sent blocks, reused with a few flipped bits to provoke matches.
    logic [7:0]  recent_blocks [32][16];
    int unsigned recent_count = 0;
    int unsigned recent_next = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    near_duplicate_block_dedup_core #(
        .BLOCK_MAX    (BLOCK_MAX),
        .STORE_BLOCKS (STORE_BLOCKS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    dedup_checker #(
        .BLOCK_MAX    (BLOCK_MAX),
        .STORE_BLOCKS (STORE_BLOCKS)
    ) pointer_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .beats_owed   (beats_owed)
    );

    function automatic int unsigned eff_of(input logic [4:0] v);
        if (v == 5'd0)
        begin
            return 1;
        end
        if (v > BLOCK_MAX)
        begin
            return BLOCK_MAX;
        end
        return v;
    endfunction

    // Offers one beat, possibly after an idle burst, and returns at the edge
    // that accepts it. Valid stays high into the next beat unless a gap is
    // drawn, so back-to-back beats never lower and raise valid in one step.
    task automatic send_beat(input logic op, input logic [7:0] data_byte);
        if (!quiet && $urandom_range(1, 100) <= gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        item.op        <= op;
        item.data_byte <= data_byte;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        beats_sent++;
        if (op == OP_CLEAR)
        begin
            run_floor = cur_width;
        end
    endtask

    // Stops offering beats and waits until every pointer beat has come back,
    // then lets a trailing non-completing beat finish inside the core.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (beats_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers; only called while the core is idle.
    task automatic configure(input logic [7:0] width_val, input logic [7:0] thresh_val,
                             input logic hi_val);
        int unsigned new_w;
        new_w = eff_of(width_val[4:0]);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_BLOCK_WIDTH;
        cfg_data     <= width_val;
        @(posedge clk);
        cfg_index    <= REG_MATCH_THRESHOLD;
        cfg_data     <= thresh_val;
        @(posedge clk);
        cfg_index    <= REG_HI_BYTE_FIRST;
        cfg_data     <= {7'($urandom_range(0, 127)), hi_val};
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_width = new_w;
        if (new_w > run_floor)
        begin
            send_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
        end
        run_floor = new_w;
    endtask

    // Picks a register setting. Widths lean small to keep blocks cheap, but
    // zero and values past the block limit show up too; upper bits of the
    // width write are junk that the register drops.
    task automatic random_config();
        logic [7:0] w;
        logic [7:0] t;
        case ($urandom_range(0, 9))
            0:       w = 8'd0;
            1:       w = 8'd16;
            2:       w = 8'($urandom_range(17, 31));
            3, 4, 5: w = 8'($urandom_range(1, 4));
            default: w = 8'($urandom_range(1, 16));
        endcase
        w[7:5] = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       t = 8'd0;
            1:       t = 8'd129;
            2:       t = 8'd255;
            3:       t = 8'($urandom_range(0, 129));
            default: t = 8'($urandom_range(1, 6));
        endcase
        configure(w, t, 1'($urandom_range(0, 1)));
    endtask

    // Sends one whole block at the current width: either a near copy of a
    // recent block (zero to three flipped bits) or fresh content.
    task automatic send_block();
        logic [7:0]  blk [16];
        int unsigned pick;
        int unsigned pos;
        if (recent_count > 0 && $urandom_range(0, 1) == 1)
        begin
            pick = $urandom_range(0, recent_count - 1);
            for (int k = 0; k < 16; k++)
            begin
                blk[k] = recent_blocks[pick][k];
            end
            repeat ($urandom_range(0, 3))
            begin
                pos = $urandom_range(0, cur_width * 8 - 1);
                blk[pos / 8][pos % 8] = ~blk[pos / 8][pos % 8];
            end
        end
        else
        begin
            pick = $urandom_range(0, 9);
            for (int k = 0; k < 16; k++)
            begin
                blk[k] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            recent_blocks[recent_next][k] = blk[k];
        end
        recent_next = (recent_next + 1) % 32;
        if (recent_count < 32)
        begin
            recent_count++;
        end
        for (int unsigned k = 0; k < cur_width; k++)
        begin
            send_beat(OP_DATA, blk[k]);
        end
    endtask

    // Mostly whole blocks; now and then a clear or a stray byte that shifts
    // the block alignment.
    task automatic run_phase(input int unsigned beats_wanted);
        int unsigned start;
        start = beats_sent;
        while (beats_sent - start < beats_wanted)
        begin
            case ($urandom_range(0, 19))
                0:       send_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
                1:       send_beat(OP_DATA, 8'($urandom_range(0, 255)));
                default: send_block();
            endcase
        end
    endtask

    // Result side back-pressure. A hold request from the stimulus gives one
    // long hold-off, counted here; otherwise short random stall bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(1, 100) <= stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run that has not finished by now has hung.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int phase_no;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_pct   = 20;
        stall_pct = 20;

        // Register defaults: width 8, exact match only, low byte first.
        // An all-zero block goes in new at pointer zero.
        repeat (8) send_beat(OP_DATA, 8'h00);
        // Start a block of all-ones and leave it unfinished, then shrink the
        // width under it: the next byte completes the block at once. With a
        // zero threshold nothing matches and the pointer comes high byte first.
        repeat (3) send_beat(OP_DATA, 8'hff);
        drain();
        configure(8'd2, 8'd0, 1'b1);
        send_beat(OP_DATA, 8'h55);
        drain();
        // Width zero acts as one; a threshold above any distance matches every
        // entry, and the highest one wins.
        configure(8'd0, 8'd129, 1'b0);
        send_beat(OP_DATA, 8'haa);
        // After a clear the store is empty again: new, then an exact repeat.
        send_beat(OP_CLEAR, 8'h00);
        send_beat(OP_DATA, 8'h0f);
        send_beat(OP_DATA, 8'h0f);
        drain();

        // Pressure: the result side holds off for a long stretch while
        // single-byte blocks keep coming, so the core backs up and stalls its
        // input. The drain afterwards pauses the sender until all is back.
        configure(8'd1, 8'd3, 1'b1);
        gap_pct  = 0;
        hold_req = 1'b1;
        repeat (12) send_beat(OP_DATA, 8'($urandom_range(0, 255)));
        drain();

        phase_no = 0;
        while (beats_sent < 790)
        begin
            drain();
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            if (phase_no == 3)
            begin
                // Two-byte blocks with a zero threshold are all new: fill the
                // store past its capacity, so pointers reach the high byte and
                // the last blocks come back flagged as not stored.
                configure(8'd2, 8'd0, 1'($urandom_range(0, 1)));
                send_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
                repeat (2 * STORE_BLOCKS + 18) send_beat(OP_DATA, 8'($urandom_range(0, 255)));
            end
            else
            begin
                random_config();
                run_phase($urandom_range(25, 50));
            end
            phase_no++;
        end

        // Last stretch with both sides running flat out.
        drain();
        quiet = 1'b1;
        random_config();
        run_phase(60);

        drain();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && beats_owed == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/ndbd_pkg.sv
design/ndbd_ram.sv
design/ndbd_ctrl.sv
design/ndbd_dp.sv
design/near_duplicate_block_dedup_core.sv
dv/dedup_checker.sv
dv/testbench.sv
